FILE: src/a2li_pkg.sv
package a2li_pkg;

    // Fraction bits of every internal angle and of the table samples.
    localparam int WFRAC      = 30;
    // Fraction bits of the magnitude ratio.
    localparam int RATIO_FRAC = 16;
    // Width of one table sample (Q.30, below pi/4, so 32 bits carry it with room).
    localparam int ENTRY_W    = 32;

    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;

    // Polynomial coefficients of the arctangent fit, Q.30.
    localparam logic signed [63:0] COEF_0 = 64'sd1073597943;
    localparam logic signed [63:0] COEF_1 = -64'sd354656388;
    localparam logic signed [63:0] COEF_2 = 64'sd193424926;
    localparam logic signed [63:0] COEF_3 = -64'sd91410863;
    localparam logic signed [63:0] COEF_4 = 64'sd22371518;

    // Sign and special-case information that follows an item down the pipeline.
    typedef struct packed {
        logic yneg;
        logic xneg;
        logic xzero;
        logic yzero;
        logic swap;
    } t_flags;

    // Divide by 2^s, rounding half away from zero. Used at elaboration only.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = (v < 0) ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -$signed(r) : $signed(r);
    endfunction

    // Horner evaluation of the arctangent polynomial on a Q.30 argument.
    function automatic logic signed [63:0] arctan_fit(input logic signed [63:0] t);
        logic signed [63:0] t2;
        logic signed [63:0] acc;
        t2  = shr_round(t * t, WFRAC);
        acc = COEF_4;
        acc = COEF_3 + shr_round(t2 * acc, WFRAC);
        acc = COEF_2 + shr_round(t2 * acc, WFRAC);
        acc = COEF_1 + shr_round(t2 * acc, WFRAC);
        acc = COEF_0 + shr_round(t2 * acc, WFRAC);
        return shr_round(t * acc, WFRAC);
    endfunction

endpackage

FILE: src/a2li_div.sv
module a2li_div #(
    parameter int MAG_W = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [MAG_W-1:0]                i_num,
    input  logic [MAG_W-1:0]                i_den,
    input  a2li_pkg::t_flags                i_flags,
    output logic                            o_valid,
    output logic [a2li_pkg::RATIO_FRAC:0]   o_ratio,
    output a2li_pkg::t_flags                o_flags
);
    import a2li_pkg::*;

    // One restoring quotient bit per stage; the numerator never exceeds the
    // denominator, so the quotient has one integer bit.
    localparam int STEPS = RATIO_FRAC + 1;

    logic               r_valid [STEPS];
    logic [MAG_W-1:0]   r_rem   [STEPS];
    logic [MAG_W-1:0]   r_den   [STEPS];
    logic [STEPS-1:0]   r_q     [STEPS];
    t_flags             r_flags [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic             p_valid;
        logic [MAG_W-1:0] p_rem;
        logic [MAG_W-1:0] p_den;
        logic [STEPS-1:0] p_q;
        t_flags           p_flags;
        logic [MAG_W:0]   n_t;
        logic             n_bit;
        logic [MAG_W-1:0] n_rem;
        logic [STEPS-1:0] n_q;

        if (j == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = i_num;
            assign p_den   = i_den;
            assign p_q     = '0;
            assign p_flags = i_flags;
        end else begin : g_next
            assign p_valid = r_valid[j-1];
            assign p_rem   = r_rem[j-1];
            assign p_den   = r_den[j-1];
            assign p_q     = r_q[j-1];
            assign p_flags = r_flags[j-1];
        end

        always_comb begin
            n_t   = (j == 0) ? {1'b0, p_rem} : {p_rem, 1'b0};
            n_bit = (n_t >= {1'b0, p_den});
            n_rem = n_bit ? MAG_W'(n_t - {1'b0, p_den}) : MAG_W'(n_t);
            n_q   = {p_q[STEPS-2:0], n_bit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else begin
                r_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]   <= n_rem;
            r_den[j]   <= p_den;
            r_q[j]     <= n_q;
            r_flags[j] <= p_flags;
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_ratio = r_q[STEPS-1];
    assign o_flags = r_flags[STEPS-1];

endmodule

FILE: src/atan2_lut_interp_top.sv
// Four-quadrant arctangent: atan2(y, x) in radians, signed with
// ANGLE_FRAC_BITS fraction bits (Q2.13 at the default settings).
// Input: a transaction is taken at each rising edge where start is high and
// busy is low. busy is always low, so a new coordinate pair can enter in
// every cycle, one transaction per clock sustained.
// Output: o_valid strobes for exactly one cycle with o_angle beside it. The
// receiver cannot push back, and the pipeline never needs it to.
// The pipeline from the accepting edge to the edge that takes the
// result: one input stage, 17 divider stages (one quotient bit each, set by
// the 17-bit ratio), then table index, table read, interpolation multiply,
// interpolation add, octant/quadrant fold and final rounding.
// The ratio min(|y|,|x|)/max(|y|,|x|) indexes a table of LUT_ENTRIES+1
// arctangent samples that is built at elaboration; its two neighboring
// samples are read in the same cycle and blended linearly.
// Reset is synchronous and active low; it clears the valid bits of all
// stages, so transactions in flight are dropped and no strobe follows.
module atan2_lut_interp_top #(
    parameter int LUT_ENTRIES     = 1024,
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      i_y_coord,
    input  logic signed [COORD_BITS-1:0]      i_x_coord,
    output logic                              o_valid,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_angle
);
    import a2li_pkg::*;

    localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 3;
    localparam int SHIFT      = WFRAC - ANGLE_FRAC_BITS;
    localparam int IDX_W      = $clog2(LUT_ENTRIES + 1);
    localparam int RATIO_W    = RATIO_FRAC + 1;
    localparam int POS_W      = RATIO_W + IDX_W;
    localparam int DIFF_W     = ENTRY_W + 1;
    localparam int PROD_W     = DIFF_W + RATIO_W;
    localparam int U_W        = ENTRY_W + 1;
    localparam int A_W        = 35;
    localparam int LATENCY    = RATIO_FRAC + 8;

    typedef logic signed [ENTRY_W-1:0] t_rom_arr [LUT_ENTRIES+1];

    // Sample i is the polynomial at the rounded point i / LUT_ENTRIES.
    function automatic t_rom_arr build_rom();
        t_rom_arr    rom;
        logic [63:0] tu;
        for (int i = 0; i <= LUT_ENTRIES; i++) begin
            tu = ((64'(i) << WFRAC) + 64'(LUT_ENTRIES / 2)) / LUT_ENTRIES;
            rom[i] = ENTRY_W'(arctan_fit($signed(tu)));
        end
        return rom;
    endfunction

    localparam t_rom_arr ROM = build_rom();

    assign busy = 1'b0;

    // Input stage: magnitudes, ordering and special cases.
    logic                  r_in_valid;
    logic [COORD_BITS-1:0] r_in_num;
    logic [COORD_BITS-1:0] r_in_den;
    t_flags                r_in_flags;
    logic [COORD_BITS-1:0] n_ay;
    logic [COORD_BITS-1:0] n_ax;
    t_flags                n_flags;

    always_comb begin
        n_ay          = i_y_coord[COORD_BITS-1] ? (~i_y_coord + 1'b1) : i_y_coord;
        n_ax          = i_x_coord[COORD_BITS-1] ? (~i_x_coord + 1'b1) : i_x_coord;
        n_flags.yneg  = i_y_coord[COORD_BITS-1];
        n_flags.xneg  = i_x_coord[COORD_BITS-1];
        n_flags.xzero = (i_x_coord == '0);
        n_flags.yzero = (i_y_coord == '0);
        n_flags.swap  = (n_ay > n_ax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_num   <= n_flags.swap ? n_ax : n_ay;
        r_in_den   <= n_flags.swap ? n_ay : n_ax;
        r_in_flags <= n_flags;
    end

    // Ratio of the smaller magnitude to the larger one.
    logic               div_valid;
    logic [RATIO_W-1:0] div_ratio;
    t_flags             div_flags;

    a2li_div #(
        .MAG_W (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_num   (r_in_num),
        .i_den   (r_in_den),
        .i_flags (r_in_flags),
        .o_valid (div_valid),
        .o_ratio (div_ratio),
        .o_flags (div_flags)
    );

    // Table position. A ratio of one or more lands on the last sample with no
    // blend; above one only happens at the origin, whose result is fixed later.
    logic                  r_a_valid;
    logic [IDX_W-1:0]      r_a_idx;
    logic [IDX_W-1:0]      r_a_idx_hi;
    logic [RATIO_FRAC-1:0] r_a_frac;
    t_flags                r_a_flags;
    logic [POS_W-1:0]      n_pos;
    logic [IDX_W-1:0]      n_idx;
    logic                  n_full;

    always_comb begin
        n_pos  = POS_W'(div_ratio) * POS_W'(LUT_ENTRIES);
        n_idx  = IDX_W'(n_pos >> RATIO_FRAC);
        n_full = (n_pos >= (POS_W'(LUT_ENTRIES) << RATIO_FRAC));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx    <= n_full ? IDX_W'(LUT_ENTRIES) : n_idx;
        r_a_idx_hi <= n_full ? IDX_W'(LUT_ENTRIES) : n_idx + 1'b1;
        r_a_frac   <= n_full ? '0 : n_pos[RATIO_FRAC-1:0];
        r_a_flags  <= div_flags;
    end

    // Table read of both neighboring samples.
    logic                       r_b_valid;
    logic signed [ENTRY_W-1:0]  r_b_lo;
    logic signed [ENTRY_W-1:0]  r_b_hi;
    logic [RATIO_FRAC-1:0]      r_b_frac;
    t_flags                     r_b_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_lo    <= ROM[r_a_idx];
        r_b_hi    <= ROM[r_a_idx_hi];
        r_b_frac  <= r_a_frac;
        r_b_flags <= r_a_flags;
    end

    // Interpolation product.
    logic                      r_c_valid;
    logic signed [PROD_W-1:0]  r_c_prod;
    logic signed [ENTRY_W-1:0] r_c_lo;
    t_flags                    r_c_flags;
    logic signed [DIFF_W-1:0]  n_diff;

    always_comb begin
        n_diff = DIFF_W'(r_b_hi) - DIFF_W'(r_b_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_prod  <= PROD_W'(n_diff) * PROD_W'($signed({1'b0, r_b_frac}));
        r_c_lo    <= r_b_lo;
        r_c_flags <= r_b_flags;
    end

    // Rounded blend added to the lower sample.
    logic                  r_d_valid;
    logic signed [U_W-1:0] r_d_u;
    t_flags                r_d_flags;
    logic [PROD_W-1:0]     n_pmag;
    logic [PROD_W-1:0]     n_prnd;
    logic signed [U_W-1:0] n_step;

    always_comb begin
        n_pmag = r_c_prod[PROD_W-1] ? PROD_W'(-r_c_prod) : PROD_W'(r_c_prod);
        n_prnd = (n_pmag + (PROD_W'(1) << (RATIO_FRAC - 1))) >> RATIO_FRAC;
        n_step = r_c_prod[PROD_W-1] ? -$signed(U_W'(n_prnd)) : $signed(U_W'(n_prnd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_u     <= U_W'(r_c_lo) + n_step;
        r_d_flags <= r_c_flags;
    end

    // Fold back into the octant, then into the quadrant.
    logic                  r_e_valid;
    logic signed [A_W-1:0] r_e_a;
    logic signed [A_W-1:0] n_oct;
    logic signed [A_W-1:0] n_ang;

    always_comb begin
        n_oct = r_d_flags.swap ? (A_W'(HALF_PI_Q30) - A_W'(r_d_u)) : A_W'(r_d_u);
        if (r_d_flags.xzero) begin
            if (r_d_flags.yzero) begin
                n_ang = '0;
            end else if (r_d_flags.yneg) begin
                n_ang = -A_W'(HALF_PI_Q30);
            end else begin
                n_ang = A_W'(HALF_PI_Q30);
            end
        end else if (!r_d_flags.xneg) begin
            n_ang = r_d_flags.yneg ? -n_oct : n_oct;
        end else begin
            n_ang = r_d_flags.yneg ? (n_oct - A_W'(PI_Q30)) : (A_W'(PI_Q30) - n_oct);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_a <= n_ang;
    end

    // Round to the output precision, half away from zero.
    logic                          r_f_valid;
    logic signed [ANGLE_BITS-1:0]  r_f_angle;
    logic [A_W-1:0]                n_amag;
    logic [A_W-1:0]                n_arnd;
    logic [ANGLE_BITS-1:0]         n_res;

    always_comb begin
        n_amag = r_e_a[A_W-1] ? A_W'(-r_e_a) : A_W'(r_e_a);
        n_arnd = (n_amag + (A_W'(1) << (SHIFT - 1))) >> SHIFT;
        n_res  = r_e_a[A_W-1] ? ANGLE_BITS'(-n_arnd) : ANGLE_BITS'(n_arnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_angle <= n_res;
    end

    assign o_valid = r_f_valid;
    assign o_angle = r_f_angle;

    localparam logic signed [ANGLE_BITS-1:0] ANG_HALF_PI =
        ANGLE_BITS'(shr_round(HALF_PI_Q30, SHIFT));
    localparam logic signed [ANGLE_BITS-1:0] ANG_PI =
        ANGLE_BITS'(shr_round(PI_Q30, SHIFT));

    // Every accepted transaction yields its strobe at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("result strobe missing after pipeline latency");

    // A strobe is only ever produced by an earlier accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    // The result stays within plus or minus pi.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= ANG_PI) && (o_angle >= -ANG_PI))
        else $error("angle out of range");

    // A point on the positive y axis gives exactly pi/2.
    a_half_pi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_x_coord == '0) && (i_y_coord > 0)
        |-> ##LATENCY (o_angle == ANG_HALF_PI))
        else $error("positive y axis does not give pi/2");

    // The upper half plane never yields a negative angle.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_y_coord[COORD_BITS-1]
        |-> ##LATENCY !o_angle[ANGLE_BITS-1])
        else $error("negative angle for non-negative y");

endmodule
